/* design/rhh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_pkg
// Shared widths, constants and pipeline payload types for the RGB to HSV/HSL
// converter.
// ----------------------------------------------------------------------------
package rhh_pkg;

  localparam int unsigned CHAN_W    = 8;   // one color channel
  localparam int unsigned HUE_W     = 9;   // hue, 0..360
  localparam int unsigned PCT_W     = 7;   // percent, 0..100
  localparam int unsigned REM_W     = 18;  // dividend / partial remainder
  localparam int unsigned QUO_W     = 9;   // quotient bits produced per lane
  localparam int unsigned DSH_W     = 17;  // divisor pre-shifted by QUO_W-1
  localparam int unsigned STAGE_BITS = 3;  // quotient bits resolved per stage

  // floor(x / 510) == (x * LVL_RECIP) >> LVL_SHIFT for every level dividend
  localparam logic [31:0] LVL_RECIP = 32'd32897;
  localparam int unsigned LVL_SHIFT = 24;

  localparam logic MODE_HSV = 1'b0;
  localparam logic MODE_HSL = 1'b1;

  // One restoring-division lane: remainder, shifted divisor, quotient so far
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DSH_W-1:0] dsh;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  // Everything one pixel carries down the divider stages
  typedef struct packed {
    div_lane_t        hue;
    div_lane_t        sat;
    logic [PCT_W-1:0] lvl;
    logic             gray;
  } pix_work_t;

endpackage

/* design/rhh_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_front
// First pipeline stage: max/min/chroma, hue numerator by dominant channel,
// the dividend/divisor pairs for hue and saturation, and the level.
// ----------------------------------------------------------------------------
module rhh_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  mode,
  input  logic                  in_vld,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  output logic                  vld_r,
  output rhh_pkg::pix_work_t    work_r
);
  import rhh_pkg::*;

  logic                    red_top;
  logic                    green_top;
  logic [CHAN_W-1:0]       mx;
  logic [CHAN_W-1:0]       mn;
  logic [CHAN_W-1:0]       chroma;
  logic signed [CHAN_W:0]  diff;
  logic [8:0]              off;
  logic signed [19:0]      diff_ext;
  logic [19:0]             off_c;
  logic signed [19:0]      hue_num;
  logic [CHAN_W:0]         sum;
  logic [CHAN_W-1:0]       sat_den;
  logic [15:0]             lvl_x;
  logic [31:0]             lvl_prod;
  pix_work_t               work_nxt;

  always_comb begin
    red_top   = (red >= green) && (red >= blue);
    green_top = !red_top && (green >= blue);

    mx = red_top ? red : (green_top ? green : blue);
    mn = red;
    if (green < mn) begin
      mn = green;
    end
    if (blue < mn) begin
      mn = blue;
    end
    chroma = mx - mn;

    // hue = offset*c + 60*diff over c; red wraps a negative diff by 360
    if (red_top) begin
      diff = $signed({1'b0, green}) - $signed({1'b0, blue});
      off  = diff[CHAN_W] ? 9'd360 : 9'd0;
    end else if (green_top) begin
      diff = $signed({1'b0, blue}) - $signed({1'b0, red});
      off  = 9'd120;
    end else begin
      diff = $signed({1'b0, red}) - $signed({1'b0, green});
      off  = 9'd240;
    end
    diff_ext = 20'(diff);
    off_c    = 20'(off) * 20'(chroma);
    hue_num  = diff_ext * 20'sd60 + $signed(off_c);

    sum = {1'b0, mx} + {1'b0, mn};
    if (mode == MODE_HSL) begin
      sat_den = (sum <= 9'd255) ? sum[CHAN_W-1:0] : CHAN_W'(9'd510 - sum);
    end else begin
      sat_den = mx;
    end

    // round half up: (2n + d) / (2d)
    work_nxt.hue.rem = {hue_num[16:0], 1'b0} + REM_W'(chroma);
    work_nxt.hue.dsh = {chroma, 1'b0, 8'b0};
    work_nxt.hue.quo = '0;

    work_nxt.sat.rem = REM_W'(chroma) * REM_W'(200) + REM_W'(sat_den);
    work_nxt.sat.dsh = {sat_den, 1'b0, 8'b0};
    work_nxt.sat.quo = '0;

    // level divides by the constant 510: multiply by its reciprocal
    if (mode == MODE_HSL) begin
      lvl_x = 16'(sum) * 16'd100 + 16'd255;
    end else begin
      lvl_x = 16'(mx) * 16'd200 + 16'd255;
    end
    lvl_prod     = 32'(lvl_x) * LVL_RECIP;
    work_nxt.lvl = lvl_prod[LVL_SHIFT +: PCT_W];

    work_nxt.gray = (chroma == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work_r <= work_nxt;
    end
  end

endmodule

/* design/rhh_div_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_div_stage
// One divider pipeline stage: resolves STAGE_BITS quotient bits of the hue
// and saturation restoring-division lanes and registers the result.
// ----------------------------------------------------------------------------
module rhh_div_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  rhh_pkg::pix_work_t    in_work,
  output logic                  vld_r,
  output rhh_pkg::pix_work_t    work_r
);
  import rhh_pkg::*;

  pix_work_t work_nxt;

  function automatic div_lane_t lane_step(input div_lane_t ln);
    div_lane_t res;
    logic      ge;
    res = ln;
    for (int i = 0; i < STAGE_BITS; i++) begin
      ge = (res.rem >= REM_W'(res.dsh));
      if (ge) begin
        res.rem = res.rem - REM_W'(res.dsh);
      end
      res.quo = {res.quo[QUO_W-2:0], ge};
      res.dsh = res.dsh >> 1;
    end
    return res;
  endfunction

  always_comb begin
    work_nxt      = in_work;
    work_nxt.hue  = lane_step(in_work.hue);
    work_nxt.sat  = lane_step(in_work.sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work_r <= work_nxt;
    end
  end

endmodule

/* design/rgb_to_hsv_hsl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_hsl
// Converts one 8-bit RGB pixel into hue in degrees and saturation plus value
// (HSV) or lightness (HSL) in percent, all rounded half up.
// ----------------------------------------------------------------------------
// The block takes one pixel every clock while the output side takes results;
// each result passes through one stage for max/min/chroma,
// the dividends and the level (a reciprocal multiply for the divide by 510),
// three divider stages that resolve three quotient bits each for hue and
// saturation, and the output register, which drives out_tvalid. Throughput is one pixel per cycle as
// long as the output side takes results; a stalled output holds the whole
// pipeline. Write cfg_output_mode (0 = HSV, 1 = HSL) only while no pixel is
// in flight. A gray pixel gives hue 0 and saturation 0; a red hue just below
// 360 may round up to 360.
// ----------------------------------------------------------------------------
module rgb_to_hsv_hsl (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // output_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // red[7:0], green[15:8], blue[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata      // hue[8:0], saturation[15:9], level[22:16], 0
);
  import rhh_pkg::*;

  logic                 mode_r;
  logic                 en;
  logic                 v1;
  logic                 v2;
  logic                 v3;
  logic                 v4;
  pix_work_t            w1;
  pix_work_t            w2;
  pix_work_t            w3;
  pix_work_t            w4;
  logic                 out_valid_r;
  logic [HUE_W-1:0]     hue_r;
  logic [PCT_W-1:0]     sat_r;
  logic [PCT_W-1:0]     lvl_r;
  logic [HUE_W-1:0]     hue_nxt;
  logic [PCT_W-1:0]     sat_nxt;
  logic [PCT_W-1:0]     lvl_nxt;

  // advance everything whenever the output register is free or drains
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HSV;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  rhh_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .mode   (mode_r),
    .in_vld (in_tvalid),
    .red    (in_tdata[7:0]),
    .green  (in_tdata[15:8]),
    .blue   (in_tdata[23:16]),
    .vld_r  (v1),
    .work_r (w1)
  );

  rhh_div_stage u_div_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v1),
    .in_work (w1),
    .vld_r   (v2),
    .work_r  (w2)
  );

  rhh_div_stage u_div_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v2),
    .in_work (w2),
    .vld_r   (v3),
    .work_r  (w3)
  );

  rhh_div_stage u_div_c (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v3),
    .in_work (w3),
    .vld_r   (v4),
    .work_r  (w4)
  );

  // gray pixels have zero chroma, so hue and saturation drop to zero
  always_comb begin
    hue_nxt = w4.gray ? '0 : w4.hue.quo;
    sat_nxt = w4.gray ? '0 : w4.sat.quo[PCT_W-1:0];
    lvl_nxt = w4.lvl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      lvl_r <= lvl_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, lvl_r, sat_r, hue_r};

`ifndef ASSERT_OFF
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> hue_r <= 9'd360)
    else $error("hue above 360");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> sat_r <= 7'd100)
    else $error("saturation above 100");

  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> lvl_r <= 7'd100)
    else $error("level above 100");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while output register free");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v4) && $stable(v1))
    else $error("pipeline moved during stall");
`endif

endmodule

/* test/color_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_result_checker
// Watches both stream channels and the mode register of the RGB to HSV/HSL
// converter, computes the expected hue, saturation and level of every pixel
// transfer and compares them in order against the results that come out.
// ----------------------------------------------------------------------------
module color_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,    // red[7:0], green[15:8], blue[23:16]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,   // hue[8:0], saturation[15:9], level[22:16], 0
  output int          mismatches,
  output int          in_flight
);
  import rhh_pkg::*;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] lvl;
  } hsx_t;

  logic mode_q = MODE_HSV;
  hsx_t pending_hsx[$];

  function automatic int div_half_up(input int num, input int den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic hsx_t rgb_to_hsx(input logic [CHAN_W-1:0] r, g, b, input logic mode);
    int rv, gv, bv, mx, mn, c, num, sum, dev;
    hsx_t res;
    rv = r;
    gv = g;
    bv = b;
    mx = rv;
    mn = rv;
    if (gv > mx) mx = gv;
    if (bv > mx) mx = bv;
    if (gv < mn) mn = gv;
    if (bv < mn) mn = bv;
    c = mx - mn;
    res = '0;
    if (c != 0) begin
      // red wins ties, then green
      if (mx == rv) begin
        num = 60 * (gv - bv);
        if (num < 0) num += 360 * c;
      end else if (mx == gv) begin
        num = 60 * (bv - rv) + 120 * c;
      end else begin
        num = 60 * (rv - gv) + 240 * c;
      end
      // a hue just below 360 may round up to 360 and is not wrapped to 0
      res.hue = HUE_W'(div_half_up(num, c));
    end
    if (mode == MODE_HSV) begin
      if (c != 0) res.sat = PCT_W'(div_half_up(100 * c, mx));
      res.lvl = PCT_W'(div_half_up(100 * mx, 255));
    end else begin
      sum = mx + mn;
      dev = sum - 255;
      if (dev < 0) dev = -dev;
      if (c != 0 && 255 - dev > 0) res.sat = PCT_W'(div_half_up(100 * c, 255 - dev));
      res.lvl = PCT_W'(div_half_up(100 * sum, 510));
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    hsx_t want, got;
    if (!rst_n) begin
      mode_q <= MODE_HSV;
      pending_hsx.delete();
      in_flight <= 0;
    end else begin
      if (cfg_wr_en) mode_q <= cfg_wr_data;
      if (in_tvalid && in_tready)
        pending_hsx.push_back(rgb_to_hsx(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16],
                                         mode_q));
      if (out_tvalid && out_tready) begin
        got.hue = out_tdata[8:0];
        got.sat = out_tdata[15:9];
        got.lvl = out_tdata[22:16];
        if (pending_hsx.size() == 0) begin
          mismatches <= mismatches + 1;
          $display("%0t: expected no result, got hue %0d sat %0d lvl %0d", $time,
                   got.hue, got.sat, got.lvl);
        end else begin
          want = pending_hsx.pop_front();
          if (want != got) begin
            mismatches <= mismatches + 1;
            $display("%0t: expected hue %0d sat %0d lvl %0d, got hue %0d sat %0d lvl %0d",
                     $time, want.hue, want.sat, want.lvl, got.hue, got.sat, got.lvl);
          end
        end
      end
      in_flight <= pending_hsx.size();
    end
  end

endmodule

/* test/tb_rgb_to_hsv_hsl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_hsl
// Drives corner pixels and long runs of random pixels through the converter
// in both HSV and HSL mode, with random gaps on both streams, a long output
// stall and drain pauses; the checker module judges every result.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_hsl;
  import rhh_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;      // red[7:0], green[15:8], blue[23:16]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;     // hue[8:0], saturation[15:9], level[22:16], 0

  int   mismatches;
  int   in_flight;
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  int   hold_off_req = 0;
  int   hold_off_seen = 0;
  int   hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb_to_hsv_hsl dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  color_result_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  // Result side: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off_req != hold_off_seen) begin
      hold_off_seen <= hold_off_req;
      hold_left <= 120;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(rx_idle_on && $urandom_range(99) < 22);
    end
  end

  task automatic send_pixel(input logic [CHAN_W-1:0] r, g, b);
    while (tx_idle_on && $urandom_range(99) < 22) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {b, g, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_corners();
    send_pixel(8'h00, 8'h00, 8'h00);   // black
    send_pixel(8'hFF, 8'hFF, 8'hFF);   // white
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'h00);   // red/green tie
    send_pixel(8'h00, 8'hFF, 8'hFF);   // green/blue tie
    send_pixel(8'hFF, 8'h00, 8'hFF);   // red/blue tie
    send_pixel(8'hFF, 8'h00, 8'h01);   // hue rounds up to 360
    send_pixel(8'h01, 8'h00, 8'h00);
    send_pixel(8'hAA, 8'h55, 8'h0F);
    send_pixel(8'h55, 8'hAA, 8'hF0);
  endtask

  function automatic logic [23:0] random_pixel();
    logic [CHAN_W-1:0] r, g, b, hi;
    int pick;
    r = CHAN_W'($urandom_range(255));
    g = CHAN_W'($urandom_range(255));
    b = CHAN_W'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 12) begin
      g = r;
      b = r;
    end else if (pick < 27) begin
      hi = CHAN_W'($urandom_range(255));
      r = CHAN_W'($urandom_range(hi));
      g = CHAN_W'($urandom_range(hi));
      b = CHAN_W'($urandom_range(hi));
      case ($urandom_range(2))
        0: begin r = hi; g = hi; end
        1: begin g = hi; b = hi; end
        default: begin r = hi; b = hi; end
      endcase
    end else if (pick < 37) begin
      // red dominant with blue at or just above green: hue close to 360 or 0
      r = CHAN_W'($urandom_range(255, 160));
      g = CHAN_W'($urandom_range(3));
      b = g + CHAN_W'($urandom_range(4));
    end else if (pick < 47) begin
      r = CHAN_W'($urandom_range(7));
      g = CHAN_W'($urandom_range(7));
      b = CHAN_W'($urandom_range(7));
    end else if (pick < 55) begin
      r = $urandom_range(1) ? 8'hFF : 8'h00;
      g = $urandom_range(1) ? 8'hFF : g;
      b = $urandom_range(1) ? 8'h00 : b;
    end
    return {b, g, r};
  endfunction

  initial begin : stimulus
    logic [23:0] px;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_corners();
    set_mode(MODE_HSL);
    send_corners();

    for (int phase = 0; phase < 6; phase++) begin
      set_mode((phase % 2 == 0) ? MODE_HSV : MODE_HSL);
      // no idling on either side in phase 2
      tx_idle_on <= (phase != 2);
      rx_idle_on <= (phase != 2);
      for (int k = 0; k < 255; k++) begin
        if (phase == 1 && k == 30) hold_off_req <= hold_off_req + 1;
        if (phase == 3 && k % 64 == 63) drain_results();
        px = random_pixel();
        send_pixel(px[7:0], px[15:8], px[23:16]);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
